/* src/mnop_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnop_pkg
// Shared types and constants of the MIDI note/octave parser.
// ----------------------------------------------------------------------------
package mnop_pkg;

    localparam int unsigned KEYS_PER_OCTAVE = 12;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE  = 1'b1;

    // Upper nibble of the channel voice status bytes
    localparam logic [3:0] STS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STS_NOTE_ON  = 4'h9;
    // 0xF8 and above: real-time bytes
    localparam logic [4:0] STS_REALTIME = 5'b11111;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NOTE = 2'd1,
        PH_VEL  = 2'd2
    } t_phase;

    typedef logic [7:0] t_midi_byte;

    typedef struct packed {
        logic [3:0] key;
        logic [6:0] velocity;
        logic       note_on;
    } t_note;

    typedef struct packed {
        logic [3:0] channel;
        logic [3:0] octave;
    } t_cfg;

endpackage

/* src/mnop_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnop_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mnop_stream_if #(
    parameter type T = mnop_pkg::t_midi_byte
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/mnop_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnop_parser
// Note message decode: parse state, configuration registers and result logic.
// ----------------------------------------------------------------------------
module mnop_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mnop_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mnop_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_step,
    input  mnop_pkg::t_midi_byte             i_byte,
    output logic                             o_res_valid,
    output mnop_pkg::t_note                  o_res
);

    mnop_pkg::t_cfg   r_cfg;
    mnop_pkg::t_phase r_phase, n_phase;
    logic             r_pend_on, n_pend_on;
    logic [3:0]       r_pend_key, n_pend_key;

    logic             w_realtime;
    logic             w_status;
    logic             w_chan_hit;
    logic [8:0]       w_start;
    logic [8:0]       w_diff;
    logic             w_in_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mnop_pkg::CFG_CHANNEL: r_cfg.channel <= i_cfg_data;
                mnop_pkg::CFG_OCTAVE:  r_cfg.octave  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_realtime = (i_byte[7:3] == mnop_pkg::STS_REALTIME);
    assign w_status   = i_byte[7];
    assign w_chan_hit = (i_byte[3:0] == r_cfg.channel);

    // window start 12*(octave+1), at most 192; data byte is below 128
    assign w_start     = 9'(mnop_pkg::KEYS_PER_OCTAVE) * ({5'd0, r_cfg.octave} + 9'd1);
    assign w_diff      = {2'b00, i_byte[6:0]} - w_start;
    assign w_in_window = ({2'b00, i_byte[6:0]} >= w_start)
                      && (w_diff < 9'(mnop_pkg::KEYS_PER_OCTAVE));

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_pend_on  = r_pend_on;
        n_pend_key = r_pend_key;
        if (i_step && !w_realtime) begin
            if (w_status) begin
                priority if (w_chan_hit && i_byte[7:4] == mnop_pkg::STS_NOTE_OFF) begin
                    n_phase   = mnop_pkg::PH_NOTE;
                    n_pend_on = 1'b0;
                end else if (w_chan_hit && i_byte[7:4] == mnop_pkg::STS_NOTE_ON) begin
                    n_phase   = mnop_pkg::PH_NOTE;
                    n_pend_on = 1'b1;
                end else begin
                    n_phase = mnop_pkg::PH_IDLE;
                end
            end else begin
                unique case (r_phase)
                    mnop_pkg::PH_NOTE: begin
                        if (w_in_window && r_pend_on) begin
                            n_phase    = mnop_pkg::PH_VEL;
                            n_pend_key = w_diff[3:0];
                        end else begin
                            n_phase = mnop_pkg::PH_IDLE;
                        end
                    end
                    default: n_phase = mnop_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step && !w_status) begin
            unique case (r_phase)
                mnop_pkg::PH_NOTE: begin
                    o_res_valid = w_in_window && !r_pend_on;
                    o_res.key   = w_diff[3:0];
                end
                mnop_pkg::PH_VEL: begin
                    o_res_valid    = 1'b1;
                    o_res.key      = r_pend_key;
                    o_res.velocity = i_byte[6:0];
                    o_res.note_on  = 1'b1;
                end
                default: o_res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mnop_pkg::PH_IDLE;
            r_pend_on  <= 1'b0;
            r_pend_key <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pend_on  <= n_pend_on;
            r_pend_key <= n_pend_key;
        end
    end

endmodule

/* src/mnop_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnop_out_stage
// Result register driving the note channel; frees itself when taken.
// ----------------------------------------------------------------------------
module mnop_out_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  mnop_pkg::t_note         i_res,
    output logic                    o_free,
    mnop_stream_if.source           o_note
);

    logic            r_valid;
    mnop_pkg::t_note r_res;

    // register can take a new result when empty or being emptied this cycle
    assign o_free = !r_valid || o_note.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_note.valid   = r_valid;
    assign o_note.payload = r_res;

endmodule

/* src/midi_note_octave_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_octave_parser_unit
// Decodes Note On / Note Off messages on one channel within one octave.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         
//  i_midi    in   midi byte (8 bits)              
//  o_note    out  key (4), velocity (7), note_on  
//  i_cfg_*   in   write port: 0 channel, 1 octave 
//
//  One byte per cycle sustained while the note channel is ready. A byte
//  lands in the input register, is decoded from there and its result, if
//  any, is loaded into the output register once that register is free.
//  Synchronous active-low reset clears the parse state, the configuration
//  and both valid flags.
//  A stalled result holds the input register; input stays ready meanwhile
//  only while that register is empty.
// ----------------------------------------------------------------------------
module midi_note_octave_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mnop_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mnop_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mnop_stream_if.sink                      i_midi,
    mnop_stream_if.source                    o_note
);

    logic                 r_in_valid;
    mnop_pkg::t_midi_byte r_in_byte;
    logic                 w_out_free;
    logic                 w_step;
    logic                 w_res_valid;
    mnop_pkg::t_note      w_res;

    assign w_step       = r_in_valid && w_out_free;
    assign i_midi.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_midi.ready) begin
            r_in_valid <= i_midi.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_midi.ready && i_midi.valid) begin
            r_in_byte <= i_midi.payload;
        end
    end

    mnop_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mnop_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_note  (o_note)
    );

    // Note Off results carry no velocity
    a_off_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_note.valid && !o_note.payload.note_on) |-> (o_note.payload.velocity == 7'd0))
        else $error("note off result with non-zero velocity");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_note.valid |-> (o_note.payload.key < 4'd12))
        else $error("key outside octave");

    // real-time bytes never produce a result
    a_realtime_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_byte[7:3] == mnop_pkg::STS_REALTIME) |-> !w_res_valid)
        else $error("result from real-time byte");

    // a result is only produced when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_note.valid && !o_note.ready) |=> (o_note.valid && $stable(o_note.payload)))
        else $error("pending result overwritten");

endmodule
